FILE: rtl/lrast_pkg.sv
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared types and constants for the line rasterizer: request and pixel
// payloads, controller/datapath command and status groups, and state codes.
// ----------------------------------------------------------------------------
package lrast_pkg;

    // Pixel grid coordinate width and the remainder accumulator width.
    localparam int COORD_BITS = 5;
    localparam int REM_BITS   = COORD_BITS + 1;
    localparam int COLOR_BITS = 32;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [REM_BITS-1:0]   rem_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    // One line request: two endpoints and a color.
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t line_color;
    } lrast_in_t;

    // One emitted pixel.
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last;
    } lrast_out_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;   // latch a new line request
        logic step;   // emit the current pixel and advance
    } lrast_cmd_t;

    // Datapath status back to the controller.
    typedef struct packed {
        logic degenerate;  // request on the input has equal endpoints
        logic last;        // current pixel is the final one of the line
    } lrast_status_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } lrast_state_t;

    // Kind of line being walked.
    typedef enum logic [1:0] {
        MODE_VERT,
        MODE_HORZ,
        MODE_SLOPE
    } lrast_mode_t;

endpackage

FILE: rtl/lrast_ctrl.sv
// ----------------------------------------------------------------------------
// lrast_ctrl
// Controller for the line rasterizer: accepts line requests, sequences the
// datapath one pixel per cycle while the output register is free, and owns the output valid flag.
// ----------------------------------------------------------------------------
module lrast_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  lrast_pkg::lrast_status_t status,
    output lrast_pkg::lrast_cmd_t    cmd
);
    import lrast_pkg::*;

    lrast_state_t state_reg;
    lrast_state_t state_next;
    logic         m_valid_reg;
    logic         m_valid_next;
    logic         out_free;

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The output register can take a new pixel when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (!status.degenerate) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    cmd.step = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid sets on each emitted pixel and clears when taken.
    always_comb begin
        if (cmd.step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/lrast_dpath.sv
// ----------------------------------------------------------------------------
// lrast_dpath
// Datapath for the line rasterizer: holds the line, walks it with an exact
// remainder accumulator, and registers each emitted pixel.
// ----------------------------------------------------------------------------
module lrast_dpath (
    input  logic                     aclk,
    input  lrast_pkg::lrast_in_t     s_data,
    input  lrast_pkg::lrast_cmd_t    cmd,
    output lrast_pkg::lrast_status_t status,
    output lrast_pkg::lrast_out_t    m_data
);
    import lrast_pkg::*;

    lrast_mode_t mode_reg;
    coord_t      col_reg;
    coord_t      row_reg;
    coord_t      end_x_reg;
    coord_t      end_y_reg;
    coord_t      adx_reg;
    coord_t      ady_reg;
    logic        sx_neg_reg;
    logic        sy_neg_reg;
    rem_t        rem_reg;
    color_t      color_reg;
    lrast_out_t  out_reg;

    lrast_mode_t mode_in;
    coord_t      adx_in;
    coord_t      ady_in;
    coord_t      col_adv;
    coord_t      row_adv;
    logic        rem_ge;
    rem_t        rem_sub;
    coord_t      row_sl;
    logic        fill;
    rem_t        rem_sl;
    coord_t      col_sl;
    logic        cur_last;

    // Classify the incoming request and take the endpoint distances.
    always_comb begin
        adx_in = (s_data.end_x > s_data.start_x) ? s_data.end_x - s_data.start_x
                                                 : s_data.start_x - s_data.end_x;
        ady_in = (s_data.end_y > s_data.start_y) ? s_data.end_y - s_data.start_y
                                                 : s_data.start_y - s_data.end_y;
        if (s_data.start_x == s_data.end_x) begin
            mode_in = MODE_VERT;
        end else if (s_data.start_y == s_data.end_y) begin
            mode_in = MODE_HORZ;
        end else begin
            mode_in = MODE_SLOPE;
        end
    end

    assign status.degenerate = (s_data.start_x == s_data.end_x) &&
                               (s_data.start_y == s_data.end_y);

    // Unit steps in the direction of the end point.
    assign col_adv = sx_neg_reg ? col_reg - coord_t'(1) : col_reg + coord_t'(1);
    assign row_adv = sy_neg_reg ? row_reg - coord_t'(1) : row_reg + coord_t'(1);

    // Sloped walk: one subtract of the column distance moves one row. If the
    // remainder still reaches the distance, the new row is a gap fill in the
    // same column; otherwise the walk moves to the next column.
    always_comb begin
        rem_ge  = rem_reg >= {1'b0, adx_reg};
        rem_sub = rem_ge ? rem_reg - {1'b0, adx_reg} : rem_reg;
        row_sl  = rem_ge ? row_adv : row_reg;
        fill    = rem_sub >= {1'b0, adx_reg};
        col_sl  = fill ? col_reg : col_adv;
        rem_sl  = fill ? rem_sub : rem_sub + {1'b0, ady_reg};
    end

    // Final pixel detection: axis lines stop before the end point.
    always_comb begin
        unique case (mode_reg)
            MODE_VERT:  cur_last = (row_adv == end_y_reg);
            MODE_HORZ:  cur_last = (col_adv == end_x_reg);
            MODE_SLOPE: cur_last = (col_reg == end_x_reg);
            default:    cur_last = 1'b1;
        endcase
    end

    assign status.last = cur_last;

    // Line registers and walk position.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= mode_in;
            col_reg    <= s_data.start_x;
            row_reg    <= s_data.start_y;
            end_x_reg  <= s_data.end_x;
            end_y_reg  <= s_data.end_y;
            adx_reg    <= adx_in;
            ady_reg    <= ady_in;
            sx_neg_reg <= s_data.end_x < s_data.start_x;
            sy_neg_reg <= s_data.end_y < s_data.start_y;
            rem_reg    <= {1'b0, ady_in};
            color_reg  <= s_data.line_color;
        end else if (cmd.step) begin
            unique case (mode_reg)
                MODE_VERT: begin
                    row_reg <= row_adv;
                end
                MODE_HORZ: begin
                    col_reg <= col_adv;
                end
                default: begin
                    col_reg <= col_sl;
                    row_reg <= row_sl;
                    rem_reg <= rem_sl;
                end
            endcase
        end
    end

    // Output pixel register.
    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            out_reg.pixel_x     <= col_reg;
            out_reg.pixel_y     <= row_reg;
            out_reg.pixel_color <= color_reg;
            out_reg.last        <= cur_last;
        end
    end

    assign m_data = out_reg;

endmodule

FILE: rtl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Turns one line request (two endpoints and a color) into its pixels, in
// order, with the last flag on the final pixel.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    lrast_in_t  (one line)
//   m_        out        m_valid/m_ready    lrast_out_t (one pixel)
//
// A line is taken from the input in ST_IDLE, then the walk loop of the datapath
// emits one pixel per cycle while m_ready does not stall the output.
// A line with equal endpoints is taken and emits nothing.
// A new request is taken only once the previous line's last pixel has been
// loaded into the output register; that pixel may still wait there.
// A stall on m_ready holds the walk; no pixel is dropped or repeated.
// Reset is synchronous on aresetn low and empties the output register.
// ----------------------------------------------------------------------------
module line_rasterizer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lrast_pkg::lrast_in_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lrast_pkg::lrast_out_t m_data
);
    import lrast_pkg::*;

    lrast_cmd_t    cmd;
    lrast_status_t status;

    // Sequencing of requests and pixels.
    lrast_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Line walk and pixel register.
    lrast_dpath u_dpath (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .status (status),
        .m_data (m_data)
    );

endmodule

FILE: rtl/lrast_checker.sv
// ----------------------------------------------------------------------------
// lrast_checker
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lrast_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input lrast_pkg::lrast_in_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input lrast_pkg::lrast_out_t m_data
);
    import lrast_pkg::*;

    // A pixel waiting on the output holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("pixel changed while stalled");

    // A line with distinct endpoints blocks the next request.
    a_busy_after_line: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        !(s_data.start_x == s_data.end_x && s_data.start_y == s_data.end_y)
        |=> !s_ready)
        else $error("request taken while a line is in progress");

    // A line with equal endpoints leaves the input open.
    a_degenerate_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        s_data.start_x == s_data.end_x && s_data.start_y == s_data.end_y
        |=> s_ready)
        else $error("empty line blocked the input");

    // Reset empties the output and opens the input.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind line_rasterizer lrast_checker u_lrast_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
